// ===== rtl/core/blt_pkg.sv =====
// Shared types, character constants and keyword matching for the line tokenizer.
package blt_pkg;

   typedef enum logic [2:0] {
      PH_START,
      PH_NUMBER,
      PH_BLANK1,
      PH_WORD,
      PH_BLANK2,
      PH_DONE
   } blt_phase_type;

   localparam logic [2:0] CODE_LET     = 3'd0;
   localparam logic [2:0] CODE_UNKNOWN = 3'd6;
   localparam logic [2:0] CODE_EMPTY   = 3'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_EQ    = 8'h3D;

   localparam int KW_COUNT = 6;
   localparam int KW_BYTES = 5;

   // Keyword text, first character in the low byte, unused bytes zero.
   localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
      40'h000054454C,   // LET
      40'h544E495250,   // PRINT
      40'h004F544F47,   // GOTO
      40'h0000004649,   // IF
      40'h004E454854,   // THEN
      40'h0045534C45    // ELSE
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd4};

   typedef struct packed {
      logic        has_number;
      logic [16:0] line_label;
      logic [2:0]  statement_code;
      logic [55:0] var_name;
      logic [2:0]  var_length;
      logic [7:0]  rest_offset;
   } blt_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB};
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   // Compares the first bytes of the word with every keyword; bytes at or past
   // the word length are masked off.
   function automatic logic [2:0] kw_code(input logic [KW_BYTES*8-1:0] head,
                                          input logic [3:0] len);
      logic [KW_BYTES*8-1:0] mask;
      logic [2:0]            code;
      code = CODE_UNKNOWN;
      for (int b = 0; b < KW_BYTES; b++) begin
         mask[b*8 +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
      end
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (len == KW_LEN[k] && ((head ^ KW_TEXT[k]) & mask) == '0) begin
            code = 3'(k);
         end
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/blt_in_stage.sv =====
// Input register that holds one character until the scanner takes it.
module blt_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_char,
   input  logic       take,
   output logic       char_valid,
   output logic [7:0] char_data
);
   import blt_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;
   logic       accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_text_char;
      end
   end

   assign char_valid = valid_ff;
   assign char_data  = char_ff;

endmodule

// ===== rtl/core/blt_scanner.sv =====
// Line state machine: line number, blank skipping, word collection and keyword match.
module blt_scanner #(
   parameter int MAX_DIGITS = 5,
   parameter int NAME_CHARS = 7,
   parameter int POS_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             text_char,
   output blt_pkg::blt_result_type result
);
   import blt_pkg::*;

   localparam int DC_W   = $clog2(MAX_DIGITS + 1);
   localparam int LEN_W  = $clog2(NAME_CHARS + 2);
   localparam int NAME_W = NAME_CHARS * 8;

   blt_phase_type        phase_ff, phase_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [DC_W-1:0]      count_ff, count_in;
   logic [16:0]          acc_ff, acc_in;
   logic [7:0]           buf_ff [NAME_CHARS];
   logic [7:0]           buf_in [NAME_CHARS];
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [2:0]           code_ff, code_in;
   logic [POS_BITS-1:0]  offset_ff, offset_in;
   logic                 seen_ff, seen_in;

   logic                 end_char, dig, blank, alnum, eq;
   logic                 take_digit, at_blank1, at_word, at_blank2;
   logic                 word_eq, word_add, word_end, rest_found;
   logic                 last_digit, long_word;
   logic [KW_BYTES*8-1:0] head;
   logic [2:0]           word_code;
   logic [3:0]           digit_val;

   logic [2:0]           fin_code;
   logic [LEN_W-1:0]     fin_len;
   logic [NAME_W-1:0]    fin_name;
   logic [2:0]           fin_vlen;
   logic [POS_BITS-1:0]  fin_offset;

   // Character classes and the path the character takes through the phases.
   always_comb begin
      end_char   = text_char == CH_NUL;
      dig        = is_digit(text_char);
      blank      = is_blank(text_char);
      alnum      = is_alnum(text_char);
      eq         = text_char == CH_EQ;
      digit_val  = text_char[3:0];
      take_digit = (phase_ff == PH_START || phase_ff == PH_NUMBER) && dig;
      at_blank1  = !take_digit && (phase_ff inside {PH_START, PH_NUMBER, PH_BLANK1});
      at_word    = (phase_ff == PH_WORD) || (at_blank1 && !blank);
      word_eq    = at_word && eq;
      word_add   = at_word && !eq && alnum;
      word_end   = at_word && !eq && !alnum;
      at_blank2  = (phase_ff == PH_BLANK2) || word_end;
      rest_found = at_blank2 && !blank;
      if (phase_ff == PH_START) begin
         last_digit = MAX_DIGITS <= 1;
      end else begin
         last_digit = count_ff == DC_W'(MAX_DIGITS - 1);
      end
      for (int b = 0; b < KW_BYTES; b++) begin
         head[b*8 +: 8] = buf_ff[b];
      end
      long_word = len_ff > LEN_W'(NAME_CHARS);
      word_code = long_word ? CODE_UNKNOWN : kw_code(head, 4'(len_ff));
   end

   always_comb begin
      phase_in = phase_ff;
      if (end_char) begin
         phase_in = PH_START;
      end else if (take_digit) begin
         phase_in = last_digit ? PH_BLANK1 : PH_NUMBER;
      end else if (rest_found) begin
         phase_in = PH_DONE;
      end else if (word_eq || at_blank2) begin
         phase_in = PH_BLANK2;
      end else if (at_word) begin
         phase_in = PH_WORD;
      end else if (at_blank1) begin
         phase_in = PH_BLANK1;
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      buf_in    = buf_ff;
      len_in    = len_ff;
      code_in   = code_ff;
      offset_in = offset_ff;
      seen_in   = seen_ff;
      if (end_char) begin
         pos_in    = '0;
         count_in  = '0;
         acc_in    = '0;
         len_in    = '0;
         code_in   = CODE_EMPTY;
         offset_in = '0;
         seen_in   = 1'b0;
      end else begin
         if (pos_ff != '1) begin
            pos_in = pos_ff + 1'b1;
         end
         if (take_digit) begin
            seen_in = 1'b1;
            if (phase_ff == PH_START) begin
               acc_in   = 17'(digit_val);
               count_in = DC_W'(1);
            end else begin
               acc_in   = 17'(acc_ff << 3) + 17'(acc_ff << 1) + 17'(digit_val);
               count_in = count_ff + 1'b1;
            end
         end
         if (word_add) begin
            for (int i = 0; i < NAME_CHARS; i++) begin
               if (len_ff == LEN_W'(i)) begin
                  buf_in[i] = text_char;
               end
            end
            if (!long_word) begin
               len_in = len_ff + 1'b1;
            end
         end
         if (word_eq) begin
            if (long_word) begin
               code_in = CODE_UNKNOWN;
               len_in  = '0;
            end else begin
               code_in = CODE_LET;
            end
         end
         if (word_end) begin
            code_in = word_code;
            len_in  = '0;
         end
         if (rest_found) begin
            offset_in = pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         pos_ff    <= '0;
         count_ff  <= '0;
         acc_ff    <= '0;
         len_ff    <= '0;
         code_ff   <= CODE_EMPTY;
         offset_ff <= '0;
         seen_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         len_ff    <= len_in;
         code_ff   <= code_in;
         offset_ff <= offset_in;
         seen_ff   <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         buf_ff <= buf_in;
      end
   end

   // Result for a line that ends on the current character. A word still open
   // at the line end is classified here, which leaves no name.
   always_comb begin
      if (phase_ff == PH_WORD) begin
         fin_code = word_code;
         fin_len  = '0;
      end else begin
         fin_code = code_ff;
         fin_len  = len_ff;
      end
      fin_name = '0;
      fin_vlen = '0;
      if (fin_code == CODE_LET && fin_len <= LEN_W'(NAME_CHARS)) begin
         for (int i = 0; i < NAME_CHARS; i++) begin
            if (LEN_W'(i) < fin_len) begin
               fin_name[i*8 +: 8] = buf_ff[i];
            end
         end
         fin_vlen = 3'(fin_len);
      end
      fin_offset = (phase_ff != PH_DONE) ? pos_ff : offset_ff;

      result.has_number     = seen_ff;
      result.line_label     = acc_ff;
      result.statement_code = fin_code;
      result.var_name       = 56'(fin_name);
      result.var_length     = fin_vlen;
      result.rest_offset    = 8'(fin_offset);
   end

endmodule

// ===== rtl/core/blt_out_stage.sv =====
// Result register and the flow control that lets the scanner take a character.
module blt_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    char_valid,
   input  logic [7:0]              char_data,
   input  blt_pkg::blt_result_type result,
   output logic                    take,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_has_number,
   output logic [16:0]             rsp_line_label,
   output logic [2:0]              rsp_statement_code,
   output logic [55:0]             rsp_var_name,
   output logic [2:0]              rsp_var_length,
   output logic [7:0]              rsp_rest_offset
);
   import blt_pkg::*;

   logic           valid_ff, valid_in;
   blt_result_type result_ff;
   logic           line_end, blocked, load;

   // Only the line end needs room in the result register.
   assign line_end = char_data == CH_NUL;
   assign blocked  = valid_ff && rsp_stall;
   assign take     = char_valid && (!line_end || !blocked);
   assign load     = take && line_end;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_has_number     = result_ff.has_number;
   assign rsp_line_label     = result_ff.line_label;
   assign rsp_statement_code = result_ff.statement_code;
   assign rsp_var_name       = result_ff.var_name;
   assign rsp_var_length     = result_ff.var_length;
   assign rsp_rest_offset    = result_ff.rest_offset;

endmodule

// ===== rtl/core/basic_line_tokenizer.sv =====
// Top level of the BASIC line tokenizer.
// The block takes one character of a BASIC line per transfer, one transfer per clock
// cycle when neither side stalls, and gives one result when the zero byte that ends
// the line is taken. A character is held in the input register, is folded into the
// line state by the scanner as it leaves that register, and the line result is
// written to the result register when the zero byte leaves the input register.
// Only a line end has to wait for a full result register, so other characters keep
// flowing while a result is held. The result carries the leading line number of up to
// MAX_DIGITS digits, the statement code (LET or assignment, PRINT, GOTO, IF, THEN,
// ELSE, unknown, empty), the assigned name of up to NAME_CHARS characters and the
// position of the first non-blank character after the keyword or '='. The position
// counter is POS_BITS wide and saturates.
module basic_line_tokenizer #(
   parameter int MAX_DIGITS = 5,
   parameter int NAME_CHARS = 7,
   parameter int POS_BITS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_number,
   output logic [16:0] rsp_line_label,
   output logic [2:0]  rsp_statement_code,
   output logic [55:0] rsp_var_name,
   output logic [2:0]  rsp_var_length,
   output logic [7:0]  rsp_rest_offset
);
   import blt_pkg::*;

   logic           char_valid;
   logic [7:0]     char_data;
   logic           take;
   blt_result_type result;

   blt_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_char (req_text_char),
      .take          (take),
      .char_valid    (char_valid),
      .char_data     (char_data)
   );

   blt_scanner #(
      .MAX_DIGITS (MAX_DIGITS),
      .NAME_CHARS (NAME_CHARS),
      .POS_BITS   (POS_BITS)
   ) u_scanner (
      .clock     (clock),
      .reset     (reset),
      .step      (take),
      .text_char (char_data),
      .result    (result)
   );

   blt_out_stage u_out_stage (
      .clock              (clock),
      .reset              (reset),
      .char_valid         (char_valid),
      .char_data          (char_data),
      .result             (result),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_has_number     (rsp_has_number),
      .rsp_line_label     (rsp_line_label),
      .rsp_statement_code (rsp_statement_code),
      .rsp_var_name       (rsp_var_name),
      .rsp_var_length     (rsp_var_length),
      .rsp_rest_offset    (rsp_rest_offset)
   );

endmodule

// ===== test/line_result_checker.sv =====
// Checker for the line tokenizer: tracks both channels, predicts line results and compares.
module line_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_text_char,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_has_number,
   input  logic [16:0] rsp_line_label,
   input  logic [2:0]  rsp_statement_code,
   input  logic [55:0] rsp_var_name,
   input  logic [2:0]  rsp_var_length,
   input  logic [7:0]  rsp_rest_offset,
   output int          failures,
   output int          outstanding,
   output int          lines_checked,
   output logic [7:0]  codes_seen
);
   import blt_pkg::*;

   localparam int         DIGIT_LIMIT = 5;
   localparam int         NAME_LIMIT  = 7;
   localparam logic [7:0] POS_LIMIT   = 8'hFF;
   localparam logic [7:0] CH_DIGIT0   = 8'h30;

   // The index of each keyword is its statement code.
   string keywords [6] = '{"LET", "PRINT", "GOTO", "IF", "THEN", "ELSE"};

   blt_phase_type  phase;
   logic [7:0]     position;
   int             digit_count;
   int unsigned    number_acc;
   logic [7:0]     word_buffer [NAME_LIMIT];
   int             word_length;
   logic [2:0]     code_held;
   logic [7:0]     offset_held;
   logic           number_seen;
   blt_result_type pending_lines [$];

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= CH_DIGIT0 && c <= 8'h39;
   endfunction

   function automatic bit is_spacing(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic bit is_word_char(input logic [7:0] c);
      return is_numeral(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic void clear_line();
      phase = PH_START;
      position = '0;
      digit_count = 0;
      number_acc = 0;
      foreach (word_buffer[i]) word_buffer[i] = '0;
      word_length = 0;
      code_held = CODE_EMPTY;
      offset_held = '0;
      number_seen = 1'b0;
   endfunction

   function automatic void classify_word();
      bit same;
      code_held = CODE_UNKNOWN;
      if (word_length <= NAME_LIMIT) begin
         for (int k = 0; k < 6 && code_held == CODE_UNKNOWN; k++) begin
            same = (keywords[k].len() == word_length);
            for (int i = 0; same && i < word_length; i++) begin
               if (word_buffer[i] != keywords[k][i]) same = 1'b0;
            end
            if (same) code_held = 3'(k);
         end
      end
      foreach (word_buffer[i]) word_buffer[i] = '0;
      word_length = 0;
   endfunction

   // Folds one character into the line state; a zero byte yields the line result.
   task automatic absorb_char(input logic [7:0] c, output bit line_end,
                              output blt_result_type res);
      logic [7:0] pos;
      pos = position;
      line_end = 1'b0;
      res = '0;
      if (c == CH_NUL) begin
         if (phase == PH_WORD) classify_word();
         if (phase != PH_DONE) offset_held = pos;
         res.has_number = number_seen;
         res.line_label = number_acc[16:0];
         res.statement_code = code_held;
         if (code_held == CODE_LET && word_length <= NAME_LIMIT) begin
            res.var_length = 3'(word_length);
            for (int i = 0; i < word_length; i++) res.var_name[8*i +: 8] = word_buffer[i];
         end
         res.rest_offset = offset_held;
         line_end = 1'b1;
         clear_line();
         return;
      end

      if (position < POS_LIMIT) position = position + 8'd1;

      if (phase == PH_START) begin
         if (is_numeral(c)) begin
            number_seen = 1'b1;
            number_acc = c - CH_DIGIT0;
            digit_count = 1;
            phase = (digit_count >= DIGIT_LIMIT) ? PH_BLANK1 : PH_NUMBER;
            return;
         end
         phase = PH_BLANK1;
      end else if (phase == PH_NUMBER) begin
         if (is_numeral(c)) begin
            number_acc = number_acc * 10 + (c - CH_DIGIT0);
            digit_count++;
            if (digit_count >= DIGIT_LIMIT) phase = PH_BLANK1;
            return;
         end
         phase = PH_BLANK1;
      end

      if (phase == PH_BLANK1) begin
         if (is_spacing(c)) return;
         phase = PH_WORD;
      end

      if (phase == PH_WORD) begin
         if (c == CH_EQ) begin
            // An over-long name cannot be a target, so it is reported as unknown.
            if (word_length <= NAME_LIMIT) begin
               code_held = CODE_LET;
            end else begin
               classify_word();
               code_held = CODE_UNKNOWN;
            end
            phase = PH_BLANK2;
            return;
         end
         if (is_word_char(c)) begin
            if (word_length < NAME_LIMIT) word_buffer[word_length] = c;
            if (word_length <= NAME_LIMIT) word_length++;
            return;
         end
         classify_word();
         phase = PH_BLANK2;
      end

      if (phase == PH_BLANK2) begin
         if (is_spacing(c)) return;
         offset_held = pos;
         phase = PH_DONE;
      end
   endtask

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      blt_result_type predicted;
      blt_result_type want;
      bit             line_end;
      if (reset) begin
         clear_line();
         pending_lines.delete();
         failures = 0;
         lines_checked = 0;
         codes_seen = '0;
      end else begin
         // The result side is checked first so that a line closed in this cycle
         // cannot stand in for a result that arrives early.
         if (rsp_valid && !rsp_stall) begin
            if (pending_lines.size() == 0) begin
               failures++;
               $display("%0t: result transfer with no line pending, code %0h offset %0h",
                        $time, rsp_statement_code, rsp_rest_offset);
            end else begin
               want = pending_lines.pop_front();
               compare_field("has_number", 64'(want.has_number), 64'(rsp_has_number));
               compare_field("line_label", 64'(want.line_label), 64'(rsp_line_label));
               compare_field("statement_code", 64'(want.statement_code),
                             64'(rsp_statement_code));
               compare_field("var_name", 64'(want.var_name), 64'(rsp_var_name));
               compare_field("var_length", 64'(want.var_length), 64'(rsp_var_length));
               compare_field("rest_offset", 64'(want.rest_offset), 64'(rsp_rest_offset));
               lines_checked++;
               codes_seen[want.statement_code] = 1'b1;
            end
         end
         if (req_valid && !req_stall) begin
            absorb_char(req_text_char, line_end, predicted);
            if (line_end) pending_lines.push_back(predicted);
         end
      end
      outstanding = pending_lines.size();
   end

endmodule

// ===== test/basic_line_tokenizer_tb.sv =====
// Top of the line tokenizer testbench: clock, reset, character stimulus and verdict.
module basic_line_tokenizer_tb;
   import blt_pkg::*;

   localparam logic [7:0] CH_DIGIT0 = 8'h30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_text_char = CH_NUL;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_has_number;
   logic [16:0] rsp_line_label;
   logic [2:0]  rsp_statement_code;
   logic [55:0] rsp_var_name;
   logic [2:0]  rsp_var_length;
   logic [7:0]  rsp_rest_offset;

   int          failures;
   int          outstanding;
   int          lines_checked;
   logic [7:0]  codes_seen;

   // While steady is set neither side inserts gaps.
   bit          steady = 1'b0;
   int          chars_sent = 0;
   int          lines_sent = 0;
   logic [7:0]  line_bytes [$];
   string       keywords [6] = '{"LET", "PRINT", "GOTO", "IF", "THEN", "ELSE"};
   string       word_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
   string       other_chars = "+-*/(),;:<>\"$#!?.";

   basic_line_tokenizer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_char      (req_text_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_has_number     (rsp_has_number),
      .rsp_line_label     (rsp_line_label),
      .rsp_statement_code (rsp_statement_code),
      .rsp_var_name       (rsp_var_name),
      .rsp_var_length     (rsp_var_length),
      .rsp_rest_offset    (rsp_rest_offset)
   );

   line_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_char      (req_text_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_has_number     (rsp_has_number),
      .rsp_line_label     (rsp_line_label),
      .rsp_statement_code (rsp_statement_code),
      .rsp_var_name       (rsp_var_name),
      .rsp_var_length     (rsp_var_length),
      .rsp_rest_offset    (rsp_rest_offset),
      .failures           (failures),
      .outstanding        (outstanding),
      .lines_checked      (lines_checked),
      .codes_seen         (codes_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("basic_line_tokenizer_tb failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // The valid is lowered only when a gap is taken, so a back-to-back transfer
   // keeps it high with a single update per step.
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_char <= c;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_char(line_bytes[i]);
      send_char(CH_NUL);
      lines_sent++;
      line_bytes.delete();
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      load_text(s);
      send_line();
   endtask

   task automatic push_blanks(input int count);
      repeat (count) line_bytes.push_back($urandom_range(0, 2) == 0 ? CH_TAB : CH_SPACE);
   endtask

   task automatic push_tail();
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 3) == 0) line_bytes.push_back(8'($urandom_range(1, 255)));
         else line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
   endtask

   task automatic build_statement_line();
      int    kind;
      string word;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) begin
         line_bytes.push_back(8'(CH_DIGIT0 + $urandom_range(0, 9)));
      end
      push_blanks($urandom_range(0, 2));
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         word = keywords[$urandom_range(0, 5)];
         if ($urandom_range(0, 7) == 0) word = word.tolower();
         load_text(word);
      end else if (kind < 9) begin
         repeat ($urandom_range(0, 9)) begin
            line_bytes.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
         end
      end
      case ($urandom_range(0, 5))
         0, 1: begin
            line_bytes.push_back(CH_EQ);
         end
         2, 3: begin
            push_blanks($urandom_range(1, 2));
         end
         4: begin
            if ($urandom_range(0, 3) == 0) line_bytes.push_back(8'($urandom_range(128, 255)));
            else line_bytes.push_back(other_chars[$urandom_range(0, other_chars.len() - 1)]);
         end
         default: begin
            return;
         end
      endcase
      push_blanks($urandom_range(0, 2));
      push_tail();
   endtask

   task automatic run_directed();
      send_text("");
      send_text("10 LET X=5");
      send_text("20 PRINT \"HI\"");
      send_text("30 GOTO 10");
      send_text("IF A=1 THEN 40");
      send_text("THEN");
      send_text("ELSE  X");
      send_text("99999 LET");
      send_text("123456PRINT");
      send_text("00000");
      send_text("  \t 42");
      send_text("LONGNAME=3");
      send_text("ABCDEFG = 1");
      send_text("=5");
      send_text("+X");
      send_text(" \t ");
      send_text("let a");
      send_text("PRINT");
      send_text("A=");
      send_text("X1\t=\t Y");
      line_bytes = '{8'h41, 8'h80, CH_SPACE, 8'hFF};
      send_line();
      // Long lines push the position counter into saturation.
      load_text("7 ");
      repeat (270) line_bytes.push_back(CH_SPACE);
      load_text("PRINT X");
      send_line();
      repeat (12) line_bytes.push_back(8'h5A);
      send_line();
   endtask

   task automatic run_random();
      int target;
      int r;
      target = 900;
      while (chars_sent < target) begin
         steady = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 99);
         if (r < 2) begin
            push_blanks($urandom_range(240, 300));
            load_text(keywords[$urandom_range(0, 5)]);
            if ($urandom_range(0, 1) == 0) load_text(" X");
         end else if (r < 15) begin
            repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(1, 255)));
         end else begin
            build_statement_line();
         end
         send_line();
      end
      steady = 1'b0;
   endtask

   // Result side: stall runs of random length, mostly short, now and then long.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (4) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d characters in %0d lines, %0d line results checked.",
               chars_sent, lines_sent, lines_checked);
      $display("Statement codes seen (bit per code): %b", codes_seen);
      if (failures == 0 && outstanding == 0) begin
         $display("basic_line_tokenizer_tb passed");
      end else begin
         $display("basic_line_tokenizer_tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/blt_pkg.sv
rtl/core/blt_in_stage.sv
rtl/core/blt_scanner.sv
rtl/core/blt_out_stage.sv
rtl/core/basic_line_tokenizer.sv
test/line_result_checker.sv
test/basic_line_tokenizer_tb.sv
